// ===== rtl/cfsm_pkg.sv =====
`default_nettype none

package cfsm_pkg;

    // Field widths of the request and response words.
    localparam int CMD_W    = 3;
    localparam int COUNT_W  = 10;
    localparam int SLOT_W   = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Width of an offset or frame length taken from one request.
    localparam int OFF_W    = 11;

    // Width of the pushed frame counter.
    localparam int FD_W     = 11;

    // Width of each link field in a frame header.
    localparam int LINK_W   = 16;

    // Default number of slots in the slot memory.
    localparam int DEPTH_DEFAULT = 1024;

    // Frame layout.
    localparam int FRAME_HDR_LEN = 1;
    localparam int FRAME_RES_OFF = 1;
    localparam int FRAME_ARG_OFF = 2;
    localparam int FRAME_VAL_OFF = 1;

    // The pushed frame counter saturates at its all-ones value.
    localparam logic [FD_W-1:0] FRAME_DEPTH_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE      = 3'd0,
        CMD_PUSH         = 3'd1,
        CMD_RETURN       = 3'd2,
        CMD_SET_RESULT   = 3'd3,
        CMD_GET_VALUE    = 3'd4,
        CMD_SET_VALUE    = 3'd5,
        CMD_GET_ARG      = 3'd6,
        CMD_SET_NEXT_ARG = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_RANGE    = 2'd2,
        STATUS_NO_FRAME = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_FINISH = 1'b1
    } back_state_t;

    // A classified command as it travels from the front end to the executor.
    typedef struct packed {
        cmd_t              op;
        logic [OFF_W-1:0]  len;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] value;
    } cfsm_entry_t;

endpackage

`default_nettype wire

// ===== rtl/cfsm_in_if.sv =====
`default_nettype none

interface cfsm_in_if;
    logic                         valid;
    logic                         ready;
    logic [cfsm_pkg::CMD_W-1:0]   cmd;
    logic [cfsm_pkg::COUNT_W-1:0] count;
    logic [cfsm_pkg::SLOT_W-1:0]  slot;
    logic [cfsm_pkg::DATA_W-1:0]  value;

    modport source (output valid, output cmd, output count, output slot, output value,
                    input ready);
    modport sink (input valid, input cmd, input count, input slot, input value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/cfsm_out_if.sv =====
`default_nettype none

interface cfsm_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfsm_pkg::DATA_W-1:0]   read_value;
    logic [cfsm_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink (input valid, input read_value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfsm_front.sv =====
`default_nettype none

module cfsm_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cfsm_in_if.sink                    req,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output cfsm_pkg::cfsm_entry_t      q_entry
);

    logic                  valid_reg;
    logic                  valid_next;
    cfsm_pkg::cfsm_entry_t entry_reg;
    cfsm_pkg::cfsm_entry_t entry_next;
    logic                  take;

    // The stage takes a word when it is empty or its word moves on.
    assign req.ready = !valid_reg || q_ready;
    assign take      = req.valid && req.ready;

    // Classify the command and work out its frame offset and length.
    always_comb
    begin
        entry_next.op    = cfsm_pkg::cmd_t'(req.cmd);
        entry_next.value = req.value;
        entry_next.len   = cfsm_pkg::OFF_W'(cfsm_pkg::FRAME_HDR_LEN)
                           + cfsm_pkg::OFF_W'(req.count);
        unique case (entry_next.op)
            cfsm_pkg::CMD_GET_VALUE, cfsm_pkg::CMD_SET_VALUE:
            begin
                entry_next.off = cfsm_pkg::OFF_W'(cfsm_pkg::FRAME_VAL_OFF)
                                 + cfsm_pkg::OFF_W'(req.slot);
            end
            cfsm_pkg::CMD_GET_ARG, cfsm_pkg::CMD_SET_NEXT_ARG:
            begin
                entry_next.off = cfsm_pkg::OFF_W'(cfsm_pkg::FRAME_ARG_OFF)
                                 + cfsm_pkg::OFF_W'(req.slot);
            end
            cfsm_pkg::CMD_RETURN, cfsm_pkg::CMD_SET_RESULT:
            begin
                entry_next.off = cfsm_pkg::OFF_W'(cfsm_pkg::FRAME_RES_OFF);
            end
            default:
            begin
                entry_next.off = '0;
            end
        endcase
    end

    // Valid flag of the stage.
    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= entry_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/cfsm_queue.sv =====
`default_nettype none

module cfsm_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire cfsm_pkg::cfsm_entry_t in_entry,
    output logic                       out_valid,
    input  wire logic                  out_pop,
    output cfsm_pkg::cfsm_entry_t      out_entry
);

    cfsm_pkg::cfsm_entry_t entries [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_entry = entries[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_pop && out_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfsm_back.sv =====
`default_nettype none

module cfsm_back #(
    parameter int DEPTH = cfsm_pkg::DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_pop,
    input  wire cfsm_pkg::cfsm_entry_t q_entry,
    cfsm_out_if.source                 rsp
);

    // Address, size and arithmetic widths follow from the memory depth.
    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int EW = ((SW > cfsm_pkg::OFF_W) ? SW : cfsm_pkg::OFF_W) + 2;

    logic [cfsm_pkg::DATA_W-1:0] slot_mem [DEPTH];

    cfsm_pkg::back_state_t state_reg;
    cfsm_pkg::back_state_t state_next;

    logic [AW-1:0]             top_base_reg;
    logic [AW-1:0]             top_base_next;
    logic [SW-1:0]             top_size_reg;
    logic [SW-1:0]             top_size_next;
    logic [AW-1:0]             next_base_reg;
    logic [AW-1:0]             next_base_next;
    logic [SW-1:0]             next_size_reg;
    logic [SW-1:0]             next_size_next;
    logic [cfsm_pkg::FD_W-1:0] frame_depth_reg;
    logic [cfsm_pkg::FD_W-1:0] frame_depth_next;

    cfsm_pkg::cmd_t pend_op_reg;
    cfsm_pkg::cmd_t pend_op_next;
    logic           pend_range_reg;
    logic           pend_range_next;

    logic [cfsm_pkg::DATA_W-1:0] rd_a_reg;
    logic [cfsm_pkg::DATA_W-1:0] rd_b_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [cfsm_pkg::DATA_W-1:0]   out_value_reg;
    cfsm_pkg::status_t             out_status_reg;

    logic                          out_free;
    logic                          out_load;
    logic [cfsm_pkg::DATA_W-1:0]   out_value;
    cfsm_pkg::status_t             out_status;

    logic [EW-1:0]                 end_w;
    logic                          resv_over;
    logic [AW-1:0]                 frame_base;
    logic [SW-1:0]                 frame_size;
    logic [EW-1:0]                 addr_w;
    logic                          in_range;
    logic [cfsm_pkg::DATA_W-1:0]   hdr_word;

    logic                          mem_we;
    logic [AW-1:0]                 mem_addr;
    logic [cfsm_pkg::DATA_W-1:0]   mem_wdata;
    logic                          rd_en;

    assign out_free = !out_valid_reg || rsp.ready;

    // End of the top frame and the overflow check for a reservation.
    assign end_w     = EW'(top_base_reg) + EW'(top_size_reg);
    assign resv_over = (end_w + EW'(q_entry.len)) > EW'(DEPTH);

    // Setting an argument of the next frame addresses the reserved frame, all else the top.
    always_comb
    begin
        if (q_entry.op == cfsm_pkg::CMD_SET_NEXT_ARG)
        begin
            frame_base = next_base_reg;
            frame_size = next_size_reg;
        end
        else
        begin
            frame_base = top_base_reg;
            frame_size = top_size_reg;
        end
    end

    // Slot address and its check against the frame and the memory.
    assign addr_w   = EW'(frame_base) + EW'(q_entry.off);
    assign in_range = (EW'(q_entry.off) < EW'(frame_size)) && (addr_w < EW'(DEPTH));

    // The header links back to the caller: base in the low half, size in the high half.
    assign hdr_word = {cfsm_pkg::LINK_W'(top_size_reg), cfsm_pkg::LINK_W'(top_base_reg)};

    // Command execution and sequencing.
    always_comb
    begin
        state_next       = state_reg;
        top_base_next    = top_base_reg;
        top_size_next    = top_size_reg;
        next_base_next   = next_base_reg;
        next_size_next   = next_size_reg;
        frame_depth_next = frame_depth_reg;
        pend_op_next     = pend_op_reg;
        pend_range_next  = pend_range_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = addr_w[AW-1:0];
        mem_wdata        = q_entry.value;
        rd_en            = 1'b0;
        out_load         = 1'b0;
        out_value        = '0;
        out_status       = cfsm_pkg::STATUS_OK;

        unique case (state_reg)
            cfsm_pkg::BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.op)
                        cfsm_pkg::CMD_RESERVE:
                        begin
                            out_load = 1'b1;
                            if (resv_over)
                            begin
                                out_status = cfsm_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                next_base_next = end_w[AW-1:0];
                                next_size_next = SW'(q_entry.len);
                            end
                        end
                        cfsm_pkg::CMD_PUSH:
                        begin
                            out_load      = 1'b1;
                            mem_we        = 1'b1;
                            mem_addr      = next_base_reg;
                            mem_wdata     = hdr_word;
                            top_base_next = next_base_reg;
                            top_size_next = next_size_reg;
                            if (frame_depth_reg != cfsm_pkg::FRAME_DEPTH_MAX)
                            begin
                                frame_depth_next = frame_depth_reg + 1'b1;
                            end
                        end
                        cfsm_pkg::CMD_RETURN:
                        begin
                            if (frame_depth_reg == '0)
                            begin
                                out_load   = 1'b1;
                                out_status = cfsm_pkg::STATUS_NO_FRAME;
                            end
                            else
                            begin
                                rd_en           = 1'b1;
                                pend_op_next    = q_entry.op;
                                pend_range_next = !in_range;
                                state_next      = cfsm_pkg::BK_FINISH;
                            end
                        end
                        cfsm_pkg::CMD_GET_VALUE, cfsm_pkg::CMD_GET_ARG:
                        begin
                            if (in_range)
                            begin
                                rd_en           = 1'b1;
                                pend_op_next    = q_entry.op;
                                pend_range_next = 1'b0;
                                state_next      = cfsm_pkg::BK_FINISH;
                            end
                            else
                            begin
                                out_load   = 1'b1;
                                out_status = cfsm_pkg::STATUS_RANGE;
                            end
                        end
                        default:
                        begin
                            // Set result, set value and set next argument.
                            out_load = 1'b1;
                            if (in_range)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                out_status = cfsm_pkg::STATUS_RANGE;
                            end
                        end
                    endcase
                end
            end
            cfsm_pkg::BK_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = cfsm_pkg::BK_IDLE;
                    if (pend_range_reg)
                    begin
                        out_status = cfsm_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        out_value = rd_a_reg;
                    end
                    // A return restores the caller frame from the header.
                    if (pend_op_reg == cfsm_pkg::CMD_RETURN)
                    begin
                        top_base_next    = AW'(rd_b_reg[cfsm_pkg::LINK_W-1:0]);
                        top_size_next    = SW'(rd_b_reg[cfsm_pkg::DATA_W-1:cfsm_pkg::LINK_W]);
                        frame_depth_next = frame_depth_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cfsm_pkg::BK_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and frame registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cfsm_pkg::BK_IDLE;
            top_base_reg    <= '0;
            top_size_reg    <= '0;
            next_base_reg   <= '0;
            next_size_reg   <= '0;
            frame_depth_reg <= '0;
            pend_op_reg     <= cfsm_pkg::CMD_RESERVE;
            pend_range_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            top_base_reg    <= top_base_next;
            top_size_reg    <= top_size_next;
            next_base_reg   <= next_base_next;
            next_size_reg   <= next_size_next;
            frame_depth_reg <= frame_depth_next;
            pend_op_reg     <= pend_op_next;
            pend_range_reg  <= pend_range_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= out_value;
            out_status_reg <= out_status;
        end
    end

    // Slot memory: one write or read port, plus a read port at the top frame header.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= slot_mem[mem_addr];
            rd_b_reg <= slot_mem[top_base_reg];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/call_frame_stack_manager_core.sv =====
// Call frame stack manager.
// Commands arrive on the req channel as words carrying cmd, count, slot and value;
// each command gives exactly one word on the rsp channel with read_value and status,
// in command order. Both channels move a word when valid and ready are high together.
// A front stage registers and classifies each command, a two-entry queue holds
// classified commands, and an executor owns the frame registers and the slot memory.
// Reserve, push and all set commands finish in the executor's idle state; get value,
// get argument and return that read the memory go on to a finish state, as the
// registered memory read must come back first (return reads the result slot and the
// header link in the same cycle on two read ports).
// A stalled receiver holds the response in the output register; the executor then
// stops, the queue fills and req.ready falls once the front stage is also full.
// Reset clears the frame registers, the frame counter and all valid flags; the slot
// memory is not cleared, and a slot is only defined once it has been written.
`default_nettype none

module call_frame_stack_manager_core #(
    parameter int DEPTH = cfsm_pkg::DEPTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfsm_in_if.sink    req,
    cfsm_out_if.source rsp
);

    logic                  fq_valid;
    logic                  fq_ready;
    cfsm_pkg::cfsm_entry_t fq_entry;
    logic                  qb_valid;
    logic                  qb_pop;
    cfsm_pkg::cfsm_entry_t qb_entry;

    // Command intake and classification.
    cfsm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_entry (fq_entry)
    );

    // Decoupling queue between intake and execution.
    cfsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_entry (qb_entry)
    );

    // Frame state, slot memory and response register.
    cfsm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_pop   (qb_pop),
        .q_entry (qb_entry),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire
